[rtl/core/cdww_pkg.sv]
// ---------------------------------------------------------------------------
// cdww_pkg
// Shared types and constants for the clamped dot window writer.
// ---------------------------------------------------------------------------
package cdww_pkg;

   // field widths
   localparam int COORD_W = 10;
   localparam int COLOR_W = 16;
   localparam int BYTE_W  = 8;
   localparam int STEP_W  = 5;   // up to 29 beats per dot
   localparam int COUNT_W = 4;   // up to 9 pixels

   // panel defaults
   localparam int PANEL_WIDTH_DEF  = 240;
   localparam int PANEL_HEIGHT_DEF = 320;

   // register map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_COL_OP = 2'd0;
   localparam logic [1:0] REG_ROW_OP = 2'd1;
   localparam logic [1:0] REG_MEM_OP = 2'd2;

   localparam logic [BYTE_W-1:0] COL_OP_RST = 8'd42;
   localparam logic [BYTE_W-1:0] ROW_OP_RST = 8'd43;
   localparam logic [BYTE_W-1:0] MEM_OP_RST = 8'd44;

   localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

   // beat positions in a dot sequence
   localparam logic [STEP_W-1:0] STEP_COL_CMD = 5'd0;
   localparam logic [STEP_W-1:0] STEP_X0_HI   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_X0_LO   = 5'd2;
   localparam logic [STEP_W-1:0] STEP_X1_HI   = 5'd3;
   localparam logic [STEP_W-1:0] STEP_X1_LO   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_ROW_CMD = 5'd5;
   localparam logic [STEP_W-1:0] STEP_Y0_HI   = 5'd6;
   localparam logic [STEP_W-1:0] STEP_Y0_LO   = 5'd7;
   localparam logic [STEP_W-1:0] STEP_Y1_HI   = 5'd8;
   localparam logic [STEP_W-1:0] STEP_Y1_LO   = 5'd9;
   localparam logic [STEP_W-1:0] STEP_MEM_CMD = 5'd10;

   // controller -> datapath
   typedef struct packed {
      logic              capture;  // latch a new dot
      logic              load;     // load output register with beat at step
      logic              last;     // this beat ends the sequence
      logic [STEP_W-1:0] step;
   } cdww_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [STEP_W-1:0] last_step;
   } cdww_status_type;

endpackage

[rtl/core/cdww_if.sv]
// ---------------------------------------------------------------------------
// cdww_if
// Valid/ready channels for dot requests and output byte beats.
// ---------------------------------------------------------------------------
interface cdww_req_if
   import cdww_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] dot_x;
   logic [COORD_W-1:0] dot_y;
   logic [COLOR_W-1:0] dot_color;

   modport source (output valid, output dot_x, output dot_y, output dot_color,
                   input ready);
   modport sink   (input valid, input dot_x, input dot_y, input dot_color,
                   output ready);
endinterface

interface cdww_rsp_if
   import cdww_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_command;
   logic              last_byte;

   modport source (output valid, output out_byte, output is_command,
                   output last_byte, input ready);
   modport sink   (input valid, input out_byte, input is_command,
                   input last_byte, output ready);
endinterface

[rtl/core/cdww_csr.sv]
// ---------------------------------------------------------------------------
// cdww_csr
// APB-style register file holding the three command opcodes.
// ---------------------------------------------------------------------------
module cdww_csr
   import cdww_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [BYTE_W-1:0]     col_op,
   output logic [BYTE_W-1:0]     row_op,
   output logic [BYTE_W-1:0]     mem_op
);

   logic [BYTE_W-1:0] col_op_ff, col_op_in;
   logic [BYTE_W-1:0] row_op_ff, row_op_in;
   logic [BYTE_W-1:0] mem_op_ff, mem_op_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      col_op_in = col_op_ff;
      row_op_in = row_op_ff;
      mem_op_in = mem_op_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_COL_OP: col_op_in = csr_pwdata[BYTE_W-1:0] & BYTE_MASK;
            REG_ROW_OP: row_op_in = csr_pwdata[BYTE_W-1:0] & BYTE_MASK;
            REG_MEM_OP: mem_op_in = csr_pwdata[BYTE_W-1:0] & BYTE_MASK;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_op_ff <= COL_OP_RST;
         row_op_ff <= ROW_OP_RST;
         mem_op_ff <= MEM_OP_RST;
      end else begin
         col_op_ff <= col_op_in;
         row_op_ff <= row_op_in;
         mem_op_ff <= mem_op_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_COL_OP: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, col_op_ff};
         REG_ROW_OP: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, row_op_ff};
         REG_MEM_OP: csr_prdata = {{(CSR_DATA_W-BYTE_W){1'b0}}, mem_op_ff};
         default:    csr_prdata = '0;
      endcase
   end

   assign col_op = col_op_ff;
   assign row_op = row_op_ff;
   assign mem_op = mem_op_ff;

endmodule

[rtl/core/cdww_ctrl.sv]
// ---------------------------------------------------------------------------
// cdww_ctrl
// Sequencer: takes a dot, then walks the beat counter through the sequence.
// ---------------------------------------------------------------------------
module cdww_ctrl
   import cdww_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  cdww_status_type status,
   output cdww_cmd_type    cmd
);

   typedef enum logic {
      IDLE,
      EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              at_last;

   assign req_ready = (state_ff == IDLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign at_last   = (step_ff == status.last_step);

   assign cmd.capture = req_valid & req_ready;
   assign cmd.load    = (state_ff == EMIT) & out_free;
   assign cmd.last    = at_last;
   assign cmd.step    = step_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         IDLE: begin
            if (cmd.capture) begin
               state_in = EMIT;
               step_in  = STEP_COL_CMD;
            end
         end
         EMIT: begin
            if (cmd.load) begin
               rsp_valid_in = 1'b1;
               if (at_last) begin
                  state_in = IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         step_ff      <= STEP_COL_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/core/cdww_dp.sv]
// ---------------------------------------------------------------------------
// cdww_dp
// Window clamp, dot registers and output beat register.
// ---------------------------------------------------------------------------
module cdww_dp
   import cdww_pkg::*;
#(
   parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)(
   input  logic               clock,
   input  cdww_cmd_type       cmd,
   input  logic [COORD_W-1:0] dot_x,
   input  logic [COORD_W-1:0] dot_y,
   input  logic [COLOR_W-1:0] dot_color,
   input  logic [BYTE_W-1:0]  col_op,
   input  logic [BYTE_W-1:0]  row_op,
   input  logic [BYTE_W-1:0]  mem_op,
   output cdww_status_type    status,
   output logic [BYTE_W-1:0]  out_byte,
   output logic               is_command,
   output logic               last_byte
);

   localparam logic [COORD_W:0]   X_LIM = (COORD_W+1)'(PANEL_WIDTH);
   localparam logic [COORD_W:0]   Y_LIM = (COORD_W+1)'(PANEL_HEIGHT);
   localparam logic [COORD_W-1:0] X_MAX = COORD_W'(PANEL_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(PANEL_HEIGHT - 1);

   logic [COORD_W-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [COORD_W-1:0] x0_in, x1_in, y0_in, y1_in;
   logic [COLOR_W-1:0] color_ff;
   logic [STEP_W-1:0]  last_step_ff, last_step_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               is_command_ff, is_command_in;
   logic               last_byte_ff;

   logic [COORD_W:0]   x_inc, y_inc;
   logic [COORD_W-1:0] x_diff, y_diff;
   logic [1:0]         w_len, h_len;
   logic [COUNT_W-1:0] pix_cnt;

   // clamp the 3x3 window; start is not clamped at the top end
   always_comb begin
      x_inc  = {1'b0, dot_x} + 1'b1;
      y_inc  = {1'b0, dot_y} + 1'b1;
      x0_in  = (dot_x == '0) ? '0 : dot_x - 1'b1;
      y0_in  = (dot_y == '0) ? '0 : dot_y - 1'b1;
      x1_in  = (x_inc >= X_LIM) ? X_MAX : x_inc[COORD_W-1:0];
      y1_in  = (y_inc >= Y_LIM) ? Y_MAX : y_inc[COORD_W-1:0];
      x_diff = x1_in - x0_in;
      y_diff = y1_in - y0_in;
      w_len  = (x0_in <= x1_in) ? x_diff[1:0] + 2'd1 : 2'd0;
      h_len  = (y0_in <= y1_in) ? y_diff[1:0] + 2'd1 : 2'd0;
      pix_cnt      = COUNT_W'(w_len) * COUNT_W'(h_len);
      last_step_in = STEP_MEM_CMD + {pix_cnt, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x0_ff        <= x0_in;
         x1_ff        <= x1_in;
         y0_ff        <= y0_in;
         y1_ff        <= y1_in;
         color_ff     <= dot_color;
         last_step_ff <= last_step_in;
      end
   end

   assign status.last_step = last_step_ff;

   // beat select
   always_comb begin
      is_command_in = 1'b0;
      case (cmd.step)
         STEP_COL_CMD: begin
            out_byte_in   = col_op;
            is_command_in = 1'b1;
         end
         STEP_X0_HI:   out_byte_in = BYTE_W'(x0_ff >> BYTE_W);
         STEP_X0_LO:   out_byte_in = x0_ff[BYTE_W-1:0];
         STEP_X1_HI:   out_byte_in = BYTE_W'(x1_ff >> BYTE_W);
         STEP_X1_LO:   out_byte_in = x1_ff[BYTE_W-1:0];
         STEP_ROW_CMD: begin
            out_byte_in   = row_op;
            is_command_in = 1'b1;
         end
         STEP_Y0_HI:   out_byte_in = BYTE_W'(y0_ff >> BYTE_W);
         STEP_Y0_LO:   out_byte_in = y0_ff[BYTE_W-1:0];
         STEP_Y1_HI:   out_byte_in = BYTE_W'(y1_ff >> BYTE_W);
         STEP_Y1_LO:   out_byte_in = y1_ff[BYTE_W-1:0];
         STEP_MEM_CMD: begin
            out_byte_in   = mem_op;
            is_command_in = 1'b1;
         end
         // pixel beats: odd step carries the high colour byte
         default:      out_byte_in = cmd.step[0] ? color_ff[COLOR_W-1:BYTE_W]
                                                 : color_ff[BYTE_W-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_byte_ff   <= out_byte_in;
         is_command_ff <= is_command_in;
         last_byte_ff  <= cmd.last;
      end
   end

   assign out_byte   = out_byte_ff;
   assign is_command = is_command_ff;
   assign last_byte  = last_byte_ff;

endmodule

[rtl/core/clamped_dot_window_writer.sv]
// ---------------------------------------------------------------------------
// clamped_dot_window_writer
// Turns one dot request into the controller byte stream for a clamped 3x3
// window: column window, row window, memory write, then pixel colour.
//
//   channel | port prefix | dir | per beat
//   --------+-------------+-----+----------------------------------------
//   request | req_        | in  | dot_x, dot_y, dot_color (one dot)
//   result  | rsp_        | out | out_byte, is_command, last_byte (1 byte)
//   config  | csr_        | in  | APB-style opcode registers at 0x0/4/8
//
// Beats: one dot yields 11 beats plus 2 per window pixel (11..29); the
//   beat counter emits at most one beat per cycle, fewer while rsp_ stalls.
// The next dot is taken once its predecessor's last beat sits in the output
//   register; that register decouples the two channels.
// Reset: synchronous, active high; clears the sequencer and output valid,
//   opcodes return to 42/43/44.
// Stalls on rsp_ hold the beat counter; nothing is dropped.
// ---------------------------------------------------------------------------
module clamped_dot_window_writer
   import cdww_pkg::*;
#(
   parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   cdww_req_if.sink              req_chan,
   cdww_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cdww_cmd_type      cmd;
   cdww_status_type   status;
   logic [BYTE_W-1:0] col_op, row_op, mem_op;

   // opcode registers
   cdww_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .col_op      (col_op),
      .row_op      (row_op),
      .mem_op      (mem_op)
   );

   // sequencer: owns both handshakes and the beat counter
   cdww_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window clamp and beat formatting
   cdww_dp #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .dot_x      (req_chan.dot_x),
      .dot_y      (req_chan.dot_y),
      .dot_color  (req_chan.dot_color),
      .col_op     (col_op),
      .row_op     (row_op),
      .mem_op     (mem_op),
      .status     (status),
      .out_byte   (rsp_chan.out_byte),
      .is_command (rsp_chan.is_command),
      .last_byte  (rsp_chan.last_byte)
   );

endmodule

[sim/clamped_dot_window_writer_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clamped_dot_window_writer_tb
// Self-checking bench: dot requests go in, every output byte beat is
// compared in order against a local model of the clamped 3x3 window stream.
// Opcode registers are swept through reset, extreme and random values.
// ---------------------------------------------------------------------------
module clamped_dot_window_writer_tb;
   import cdww_pkg::*;

   localparam int PANEL_W       = PANEL_WIDTH_DEF;
   localparam int PANEL_H       = PANEL_HEIGHT_DEF;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_MAX    = 10;
   localparam int HOLD_CYCLES   = 300;      // long sink hold-off
   localparam logic [1:0] REG_UNUSED = 2'd3; // unmapped slot at 0xC

   // one expected output beat
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              is_command;
      logic              last_byte;
   } dot_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cdww_req_if req_chan ();
   cdww_rsp_if rsp_chan ();

   clamped_dot_window_writer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the opcode registers, indexed by register number
   logic [BYTE_W-1:0] opcode_shadow [0:2];

   dot_beat_type pending_beats [$];   // beats still owed by the block

   int fail_count    = 0;
   int dots_sent     = 0;
   int beats_checked = 0;
   int empty_windows = 0;
   int edge_windows  = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;

   // sink stall control: test code asks for a hold-off, stall process counts it
   int hold_request  = 0;

   // -------------------------------------------------------------------------
   // clock, watchdog
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d beats still owed",
               cycle_count, pending_beats.size());
      $display("FAIL clamped_dot_window_writer");
      $finish;
   end

   // -------------------------------------------------------------------------
   // failure bookkeeping
   // -------------------------------------------------------------------------
   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // -------------------------------------------------------------------------
   // window model: start is centre-1 (floored at 0), end is centre+1 clamped
   // to the panel edge; a start past the clamped end means an empty span
   // -------------------------------------------------------------------------
   function automatic void window_span(input int centre, input int limit,
                                       output int lo, output int hi,
                                       output int len);
      lo  = (centre == 0) ? 0 : centre - 1;
      hi  = (centre + 1 >= limit) ? limit - 1 : centre + 1;
      len = (lo <= hi) ? hi - lo + 1 : 0;
   endfunction

   function automatic dot_beat_type make_beat(input logic [BYTE_W-1:0] value,
                                              input logic is_command);
      dot_beat_type b;
      b.value      = value;
      b.is_command = is_command;
      b.last_byte  = 1'b0;
      return b;
   endfunction

   // queue the full byte stream that one dot should produce
   task automatic queue_dot_stream(input logic [COORD_W-1:0] x,
                                   input logic [COORD_W-1:0] y,
                                   input logic [COLOR_W-1:0] color);
      dot_beat_type stream [$];
      int           x0, x1, w, y0, y1, h, npix;
      window_span(int'(x), PANEL_W, x0, x1, w);
      window_span(int'(y), PANEL_H, y0, y1, h);
      npix = w * h;
      if (npix == 0) empty_windows++;
      else if (npix < 9) edge_windows++;

      stream.push_back(make_beat(opcode_shadow[REG_COL_OP], 1'b1));
      stream.push_back(make_beat(x0[15:8], 1'b0));
      stream.push_back(make_beat(x0[7:0], 1'b0));
      stream.push_back(make_beat(x1[15:8], 1'b0));
      stream.push_back(make_beat(x1[7:0], 1'b0));
      stream.push_back(make_beat(opcode_shadow[REG_ROW_OP], 1'b1));
      stream.push_back(make_beat(y0[15:8], 1'b0));
      stream.push_back(make_beat(y0[7:0], 1'b0));
      stream.push_back(make_beat(y1[15:8], 1'b0));
      stream.push_back(make_beat(y1[7:0], 1'b0));
      stream.push_back(make_beat(opcode_shadow[REG_MEM_OP], 1'b1));
      for (int i = 0; i < npix && i < 9; i++) begin
         stream.push_back(make_beat(color[15:8], 1'b0));
         stream.push_back(make_beat(color[7:0], 1'b0));
      end
      // empty window: the memory-write command itself closes the sequence
      stream[stream.size()-1].last_byte = 1'b1;
      foreach (stream[i]) pending_beats.push_back(stream[i]);
   endtask

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   // Offer one dot and hold it until accepted. valid stays high on return so
   // back-to-back calls never drop it; dot_gap lowers it.
   task automatic send_dot(input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y,
                           input logic [COLOR_W-1:0] color);
      req_chan.valid     <= 1'b1;
      req_chan.dot_x     <= x;
      req_chan.dot_y     <= y;
      req_chan.dot_color <= color;
      do @(posedge clock); while (!req_chan.ready);
      queue_dot_stream(x, y, color);
      dots_sent++;
   endtask

   task automatic dot_gap(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // mostly on-panel dots, a good share hugging the edges, the rest anywhere
   // in the 10-bit range (often off-panel)
   task automatic send_random_dot();
      int sel;
      logic [COORD_W-1:0] x, y;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         x = COORD_W'($urandom_range(0, PANEL_W - 1));
         y = COORD_W'($urandom_range(0, PANEL_H - 1));
      end else if (sel < 78) begin
         x = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 2))
                                  : COORD_W'($urandom_range(PANEL_W - 3, PANEL_W + 2));
         y = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 2))
                                  : COORD_W'($urandom_range(PANEL_H - 3, PANEL_H + 2));
      end else begin
         x = COORD_W'($urandom);
         y = COORD_W'($urandom);
      end
      send_dot(x, y, COLOR_W'($urandom));
   endtask

   // random dots in bursts of random length, random gaps between bursts;
   // some bursts run straight into the next
   task automatic run_dots(input int count);
      int burst_left;
      burst_left = 0;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (i != 0 && $urandom_range(0, 3) != 0)
               dot_gap($urandom_range(1, 32));
         end
         send_random_dot();
         burst_left--;
      end
   endtask

   // stop offering and wait until the block owes nothing
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // register port: setup cycle, then access cycle until pready
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic [1:0] idx, input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      // upper bits are junk; only the low byte is kept
      csr_pwdata  <= {24'($urandom_range(0, 32'hFFFFFF)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (idx != REG_UNUSED) opcode_shadow[idx] = value;
      csr_writes++;
   endtask

   task automatic csr_check(input logic [1:0] idx);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (csr_prdata !== CSR_DATA_W'(opcode_shadow[idx]))
         note_failure($sformatf("reg %0d read exp %0h got %0h",
                                idx, opcode_shadow[idx], csr_prdata));
   endtask

   task automatic set_opcodes(input logic [BYTE_W-1:0] col_op,
                              input logic [BYTE_W-1:0] row_op,
                              input logic [BYTE_W-1:0] mem_op);
      csr_write(REG_COL_OP, col_op);
      csr_write(REG_ROW_OP, row_op);
      csr_write(REG_MEM_OP, mem_op);
      csr_check(REG_COL_OP);
      csr_check(REG_ROW_OP);
      csr_check(REG_MEM_OP);
   endtask

   // -------------------------------------------------------------------------
   // sink side: stall pattern changes every stretch; a requested hold-off
   // overrides it for its full length
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      int stretch_left;
      int stall_pct;
      hold_left    = 0;
      stretch_left = 0;
      stall_pct    = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(32, 256);
            case ($urandom_range(0, 3))
               0: begin stall_pct = 0;  end   // no stalls at all
               1: begin stall_pct = 20; end
               2: begin stall_pct = 50; end
               default: begin stall_pct = 85; end
            endcase
         end
         stretch_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // beat checker: every accepted beat against the oldest owed one
   initial begin
      dot_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            beats_checked++;
            if (pending_beats.size() == 0) begin
               note_failure($sformatf("unexpected beat %0h cmd %0b last %0b",
                                      rsp_chan.out_byte, rsp_chan.is_command,
                                      rsp_chan.last_byte));
            end else begin
               want = pending_beats.pop_front();
               if (rsp_chan.out_byte !== want.value ||
                   rsp_chan.is_command !== want.is_command ||
                   rsp_chan.last_byte !== want.last_byte)
                  note_failure($sformatf(
                     "beat exp byte %0h cmd %0b last %0b, got byte %0h cmd %0b last %0b",
                     want.value, want.is_command, want.last_byte,
                     rsp_chan.out_byte, rsp_chan.is_command, rsp_chan.last_byte));
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // reset opcodes read back, and the unmapped slot swallows writes
   task automatic test_register_reset();
      csr_check(REG_COL_OP);
      csr_check(REG_ROW_OP);
      csr_check(REG_MEM_OP);
      csr_write(REG_UNUSED, 8'h5A);
      csr_check(REG_COL_OP);
      csr_check(REG_ROW_OP);
      csr_check(REG_MEM_OP);
   endtask

   // corners: origin, panel edges, one past, well past, full 10-bit range
   task automatic test_directed_corners();
      send_dot(10'd0,   10'd0,   16'h0000);
      send_dot(10'd1,   10'd1,   16'hFFFF);
      send_dot(10'd239, 10'd319, 16'hA5A5);
      send_dot(10'd238, 10'd318, 16'h5A5A);
      send_dot(10'd0,   10'd319, 16'h8001);
      send_dot(10'd239, 10'd0,   16'h7FFE);
      send_dot(10'd240, 10'd320, 16'h1234);  // one past: 1x1 window on the edge
      send_dot(10'd241, 10'd100, 16'hFEDC);  // column span empty
      send_dot(10'd100, 10'd321, 16'h0F0F);  // row span empty
      send_dot(10'd1023, 10'd1023, 16'hF0F0);
      send_dot(10'd1023, 10'd0,  16'h00FF);
      send_dot(10'd0,   10'd1023, 16'hFF00);
      send_dot(10'd120, 10'd160, 16'hCAFE);
      send_dot(10'd512, 10'd256, 16'h3C3C);
      wait_drained();
   endtask

   // all-zero and all-ones opcodes with a few corner dots each
   task automatic test_opcode_extremes();
      set_opcodes(8'h00, 8'h00, 8'h00);
      send_dot(10'd0,   10'd0,   16'hFFFF);
      send_dot(10'd120, 10'd200, 16'h0000);
      send_dot(10'd300, 10'd5,   16'hAAAA);
      wait_drained();
      set_opcodes(8'hFF, 8'hFF, 8'hFF);
      send_dot(10'd239, 10'd319, 16'h5555);
      send_dot(10'd60,  10'd700, 16'h0001);
      send_dot(10'd2,   10'd2,   16'h8000);
      wait_drained();
   endtask

   // sink goes dark while dots keep coming: the block must fill and push back
   task automatic test_backpressure();
      set_opcodes(8'h2A, 8'h2B, 8'h2C);
      hold_request = HOLD_CYCLES;
      for (int i = 0; i < 16; i++) send_random_dot();
      wait_drained();
   endtask

   // sender stops until every owed beat is out, then resumes
   task automatic test_drain_pause();
      run_dots(20);
      wait_drained();
      run_dots(20);
      wait_drained();
   endtask

   // bulk random traffic across several register settings
   task automatic test_random_settings();
      set_opcodes(COL_OP_RST, ROW_OP_RST, MEM_OP_RST);
      run_dots(100);
      wait_drained();
      set_opcodes(8'h00, 8'hFF, 8'h00);
      run_dots(80);
      wait_drained();
      set_opcodes(8'hFF, 8'h00, 8'hFF);
      run_dots(80);
      wait_drained();
      for (int p = 0; p < 3; p++) begin
         set_opcodes(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
         run_dots(80);
         wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // main sequence
   // -------------------------------------------------------------------------
   initial begin
      opcode_shadow[REG_COL_OP] = COL_OP_RST;
      opcode_shadow[REG_ROW_OP] = ROW_OP_RST;
      opcode_shadow[REG_MEM_OP] = MEM_OP_RST;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.dot_x     <= '0;
      req_chan.dot_y     <= '0;
      req_chan.dot_color <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_register_reset();
      test_directed_corners();
      test_opcode_extremes();
      test_backpressure();
      test_drain_pause();
      test_random_settings();

      // settle: anything after the last owed beat is a stray
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_beats.size() != 0)
         note_failure($sformatf("%0d beats never arrived", pending_beats.size()));
      if (fail_count > REPORT_MAX)
         $display("%0d further mismatches not shown", fail_count - REPORT_MAX);

      $display("run: %0d dots (%0d clipped windows, %0d empty), %0d beats checked",
               dots_sent, edge_windows, empty_windows, beats_checked);
      $display("     %0d register writes, %0d failures, %0d cycles",
               csr_writes, fail_count, cycle_count);
      if (fail_count == 0) begin
         $display("PASS clamped_dot_window_writer");
      end else begin
         $display("FAIL clamped_dot_window_writer");
      end
      $finish;
   end

endmodule
